// File: design/round_robin_thread_table_defines.svh
// Assertion macros used by the checker file of the thread table.
`ifndef ROUND_ROBIN_THREAD_TABLE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_TABLE_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock, off during reset.
`define RRTT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock, off during reset.
`define RRTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rrtt_pkg.sv
// Types and codes shared by the round-robin thread table files.
package rrtt_pkg;

   localparam int TARGET_W = 4;
   localparam int ID_OUT_W = 3;

   typedef enum logic [1:0] {
      ACT_CREATE,
      ACT_YIELD,
      ACT_EXIT,
      ACT_JOIN
   } action_type;

   typedef enum logic [1:0] {
      SLOT_UNUSED,
      SLOT_RUNNABLE,
      SLOT_RUNNING,
      SLOT_FINISHED
   } slot_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_BAD_ID,
      STAT_WAITING
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_JOIN_CHK,
      FSM_SCAN,
      FSM_WR2,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      action_type            action;
      logic [TARGET_W-1:0]   target_id;
   } cmd_type;

   typedef struct packed {
      status_type            status;
      logic [ID_OUT_W-1:0]   created_id;
      logic                  switched;
      logic [ID_OUT_W-1:0]   previous_id;
      logic [ID_OUT_W-1:0]   running_id;
   } result_type;

endpackage

// File: design/rrtt_engine.sv
// Slot-state memory and the sequencer that scans and updates it.
module rrtt_engine #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  rrtt_pkg::cmd_type    cmd,
   output logic                 res_valid,
   input  logic                 res_ready,
   output rrtt_pkg::result_type res
);

   localparam int ID_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   rrtt_pkg::slot_type   mem [SLOT_COUNT];
   rrtt_pkg::slot_type   rd_data_ff;
   logic [ID_W-1:0]      rd_addr;
   logic                 we;
   logic [ID_W-1:0]      wa;
   rrtt_pkg::slot_type   wd;

   rrtt_pkg::fsm_type    state_ff, state_in;
   logic [ID_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [ID_W-1:0]      cur_ff, cur_in;
   rrtt_pkg::cmd_type    cmd_ff, cmd_in;
   logic [ID_W-1:0]      prev_ff, prev_in;
   rrtt_pkg::slot_type   prev_state_ff, prev_state_in;
   logic                 pcap_ff, pcap_in;
   logic [ID_W-1:0]      iss_idx_ff, iss_idx_in;
   logic [CNT_W-1:0]     iss_cnt_ff, iss_cnt_in;
   logic [ID_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic                 chk_last_ff, chk_last_in;
   rrtt_pkg::result_type res_ff, res_in;

   logic                 issuing;
   logic                 bad_id;
   rrtt_pkg::slot_type   scan_code;
   logic [ID_W-1:0]      cmd_tgt;
   logic [ID_W-1:0]      cmd_ff_tgt;

   function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] i);
      return (i == ID_W'(SLOT_COUNT - 1)) ? '0 : i + ID_W'(1);
   endfunction

   assign cmd_tgt    = ID_W'(cmd.target_id);
   assign cmd_ff_tgt = ID_W'(cmd_ff.target_id);
   assign bad_id     = {1'b0, cmd.target_id} >= (rrtt_pkg::TARGET_W + 1)'(SLOT_COUNT);
   assign issuing    = iss_cnt_ff < CNT_W'(SLOT_COUNT);
   assign scan_code  = (cmd_ff.action == rrtt_pkg::ACT_CREATE) ?
                       rrtt_pkg::SLOT_UNUSED : rrtt_pkg::SLOT_RUNNABLE;
   assign res        = res_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rrtt_pkg::FSM_CLEAR;
         clr_idx_ff <= '0;
         cur_ff     <= '0;
         pcap_ff    <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         cur_ff     <= cur_in;
         pcap_ff    <= pcap_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      prev_ff       <= prev_in;
      prev_state_ff <= prev_state_in;
      iss_idx_ff    <= iss_idx_in;
      iss_cnt_ff    <= iss_cnt_in;
      chk_idx_ff    <= chk_idx_in;
      chk_last_ff   <= chk_last_in;
      res_ff        <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      cur_in        = cur_ff;
      cmd_in        = cmd_ff;
      prev_in       = prev_ff;
      prev_state_in = prev_state_ff;
      pcap_in       = 1'b0;
      iss_idx_in    = iss_idx_ff;
      iss_cnt_in    = iss_cnt_ff;
      chk_idx_in    = iss_idx_ff;
      chk_vld_in    = 1'b0;
      chk_last_in   = 1'b0;
      res_in        = res_ff;
      we            = 1'b0;
      wa            = clr_idx_ff;
      wd            = rrtt_pkg::SLOT_UNUSED;
      rd_addr       = cur_ff;
      cmd_ready     = 1'b0;
      res_valid     = 1'b0;

      case (state_ff)
         rrtt_pkg::FSM_CLEAR: begin
            we = 1'b1;
            wa = clr_idx_ff;
            wd = (clr_idx_ff == '0) ? rrtt_pkg::SLOT_RUNNING : rrtt_pkg::SLOT_UNUSED;
            if (clr_idx_ff == ID_W'(SLOT_COUNT - 1)) begin
               state_in = rrtt_pkg::FSM_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + ID_W'(1);
            end
         end
         rrtt_pkg::FSM_IDLE: begin
            cmd_ready = 1'b1;
            // join reads its target, yield reads the running slot
            rd_addr = (cmd.action == rrtt_pkg::ACT_JOIN) ? cmd_tgt : cur_ff;
            if (cmd_valid) begin
               cmd_in             = cmd;
               prev_in            = cur_ff;
               res_in.status      = rrtt_pkg::STAT_OK;
               res_in.created_id  = '0;
               res_in.switched    = 1'b0;
               res_in.previous_id = rrtt_pkg::ID_OUT_W'(cur_ff);
               res_in.running_id  = rrtt_pkg::ID_OUT_W'(cur_ff);
               iss_idx_in         = wrap_inc(cur_ff);
               iss_cnt_in         = '0;
               case (cmd.action)
                  rrtt_pkg::ACT_CREATE: begin
                     iss_idx_in = '0;
                     state_in   = rrtt_pkg::FSM_SCAN;
                  end
                  rrtt_pkg::ACT_YIELD: begin
                     pcap_in  = 1'b1;
                     state_in = rrtt_pkg::FSM_SCAN;
                  end
                  rrtt_pkg::ACT_EXIT: begin
                     we            = 1'b1;
                     wa            = cur_ff;
                     wd            = rrtt_pkg::SLOT_FINISHED;
                     prev_state_in = rrtt_pkg::SLOT_FINISHED;
                     state_in      = rrtt_pkg::FSM_SCAN;
                  end
                  rrtt_pkg::ACT_JOIN: begin
                     if (bad_id) begin
                        res_in.status = rrtt_pkg::STAT_BAD_ID;
                        state_in      = rrtt_pkg::FSM_DONE;
                     end else begin
                        state_in = rrtt_pkg::FSM_JOIN_CHK;
                     end
                  end
                  default: begin
                     state_in = rrtt_pkg::FSM_DONE;
                  end
               endcase
            end
         end
         rrtt_pkg::FSM_JOIN_CHK: begin
            case (rd_data_ff)
               rrtt_pkg::SLOT_FINISHED: begin
                  we       = 1'b1;
                  wa       = cmd_ff_tgt;
                  wd       = rrtt_pkg::SLOT_UNUSED;
                  state_in = rrtt_pkg::FSM_DONE;
               end
               rrtt_pkg::SLOT_UNUSED: begin
                  state_in = rrtt_pkg::FSM_DONE;
               end
               default: begin
                  // live target: yield once and report waiting
                  res_in.status = rrtt_pkg::STAT_WAITING;
                  rd_addr       = cur_ff;
                  pcap_in       = 1'b1;
                  state_in      = rrtt_pkg::FSM_SCAN;
               end
            endcase
         end
         rrtt_pkg::FSM_SCAN: begin
            if (pcap_ff) begin
               prev_state_in = rd_data_ff;
            end
            rd_addr = iss_idx_ff;
            if (issuing) begin
               iss_idx_in  = wrap_inc(iss_idx_ff);
               iss_cnt_in  = iss_cnt_ff + CNT_W'(1);
               chk_vld_in  = 1'b1;
               chk_last_in = (iss_cnt_ff == CNT_W'(SLOT_COUNT - 1));
            end
            if (chk_vld_ff && (rd_data_ff == scan_code)) begin
               if (cmd_ff.action == rrtt_pkg::ACT_CREATE) begin
                  we                = 1'b1;
                  wa                = chk_idx_ff;
                  wd                = rrtt_pkg::SLOT_RUNNABLE;
                  res_in.created_id = rrtt_pkg::ID_OUT_W'(chk_idx_ff);
                  state_in          = rrtt_pkg::FSM_DONE;
               end else if (chk_idx_ff == prev_ff) begin
                  state_in = rrtt_pkg::FSM_DONE;
               end else begin
                  we                = 1'b1;
                  wa                = chk_idx_ff;
                  wd                = rrtt_pkg::SLOT_RUNNING;
                  cur_in            = chk_idx_ff;
                  res_in.switched   = 1'b1;
                  res_in.running_id = rrtt_pkg::ID_OUT_W'(chk_idx_ff);
                  state_in = (prev_state_ff == rrtt_pkg::SLOT_RUNNING) ?
                             rrtt_pkg::FSM_WR2 : rrtt_pkg::FSM_DONE;
               end
            end else if (chk_vld_ff && chk_last_ff) begin
               if (cmd_ff.action == rrtt_pkg::ACT_CREATE) begin
                  res_in.status = rrtt_pkg::STAT_FULL;
               end
               state_in = rrtt_pkg::FSM_DONE;
            end
         end
         rrtt_pkg::FSM_WR2: begin
            // old running slot goes back to runnable
            we       = 1'b1;
            wa       = prev_ff;
            wd       = rrtt_pkg::SLOT_RUNNABLE;
            state_in = rrtt_pkg::FSM_DONE;
         end
         rrtt_pkg::FSM_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = rrtt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = rrtt_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

// File: design/round_robin_thread_table.sv
// Top level of the round-robin thread table: request port, engine, response register.
//
// Round-robin thread table. Each request word (create, yield, exit, join) produces
// exactly one response word. Slot states live in a SLOT_COUNT-entry memory with one
// read and one write port; the sequencer reads one entry per cycle. A bad join id
// goes from idle straight to the response state; any other join first reads its
// target slot, and an unused or finished target ends the request there. A create,
// yield or exit scans the entries until a hit or the last entry. Demoting the old
// running slot adds a write state after the scan; it only follows a hit before the
// last entry. A join that has to wait reads its target and then runs a yield scan.
// Items are handled one at a time; once the response register has loaded the word,
// the engine is back in idle and can take the next request.
// A new request is taken while the previous response still waits in the output
// register. After reset a clearing pass writes every memory entry (slot 0 running,
// the rest unused) before the first request is accepted. Slot numbers in the id
// fields are the low 3 bits of the slot index.
module round_robin_thread_table #(
   parameter int SLOT_COUNT = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [3:0] req_target_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_created_id,
   output logic       rsp_switched,
   output logic [2:0] rsp_previous_id,
   output logic [2:0] rsp_running_id
);

   rrtt_pkg::cmd_type    cmd;
   rrtt_pkg::result_type res;
   logic                 res_valid;
   logic                 res_ready;

   logic                 rsp_valid_ff, rsp_valid_in;
   rrtt_pkg::result_type rsp_word_ff, rsp_word_in;

   assign cmd.action    = rrtt_pkg::action_type'(req_action);
   assign cmd.target_id = req_target_id;

   rrtt_engine #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_valid),
      .cmd_ready (req_ready),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register takes a new word when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_word_ff.status;
   assign rsp_created_id  = rsp_word_ff.created_id;
   assign rsp_switched    = rsp_word_ff.switched;
   assign rsp_previous_id = rsp_word_ff.previous_id;
   assign rsp_running_id  = rsp_word_ff.running_id;

endmodule

// File: design/rrtt_checker.sv
// Port-level assertion checker for the thread table, bound to the top level.
`include "round_robin_thread_table_defines.svh"

module rrtt_checker #(
   parameter int SLOT_COUNT = 8
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_action,
   input logic [3:0] req_target_id,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_created_id,
   input logic       rsp_switched,
   input logic [2:0] rsp_previous_id,
   input logic [2:0] rsp_running_id
);

   logic req_seen;
   logic refused;
   logic ids_distinct;

   assign req_seen     = req_valid && req_ready && (req_action == req_action)
                         && (req_target_id == req_target_id);
   assign refused      = (rsp_status == rrtt_pkg::STAT_FULL)
                         || (rsp_status == rrtt_pkg::STAT_BAD_ID);
   assign ids_distinct = rsp_running_id != rsp_previous_id;

   // response valid held until the word is taken
   `RRTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped before taken")

   // one word in flight: no back-to-back acceptance
   `RRTT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_seen, !req_ready, "request accepted while busy")

   // switch flag agrees with the id fields when ids are not folded
   `RRTT_ASSERT_NOW(a_switch_ids, clock, reset, rsp_valid && (SLOT_COUNT <= 8), rsp_switched == ids_distinct, "switched flag disagrees with ids")

   // refused requests change nothing
   `RRTT_ASSERT_NOW(a_refused_quiet, clock, reset, rsp_valid && refused, !rsp_switched && (rsp_created_id == 3'd0), "refused request had an effect")

endmodule

bind round_robin_thread_table rrtt_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (.*);

// File: dv/round_robin_thread_table_test.sv
// Self-checking testbench for the round-robin thread table: directed and random words.
`timescale 1ns / 1ps

class thread_table_scoreboard;
   localparam int SLOTS = 8;

   rrtt_pkg::slot_type   slot_state [SLOTS];
   int unsigned          current;
   rrtt_pkg::result_type pending_responses [$];
   int unsigned          mismatches;
   int unsigned          words_in;
   int unsigned          words_out;
   int unsigned          status_tally [4];
   int unsigned          switch_tally;

   function new();
      for (int k = 0; k < SLOTS; k++) slot_state[k] = rrtt_pkg::SLOT_UNUSED;
      slot_state[0] = rrtt_pkg::SLOT_RUNNING;
      current = 0;
      mismatches = 0;
      words_in = 0;
      words_out = 0;
      switch_tally = 0;
      for (int k = 0; k < 4; k++) status_tally[k] = 0;
   endfunction

   // Round-robin search from the slot after the running one.
   function bit rotate_to_next();
      int unsigned prev;
      int unsigned idx;
      bit          moved;
      prev = current;
      moved = 1'b0;
      for (int k = 1; k <= SLOTS; k++) begin
         idx = (prev + k) % SLOTS;
         if (!moved && slot_state[idx] == rrtt_pkg::SLOT_RUNNABLE) begin
            if (idx != prev) begin
               if (slot_state[prev] == rrtt_pkg::SLOT_RUNNING)
                  slot_state[prev] = rrtt_pkg::SLOT_RUNNABLE;
               slot_state[idx] = rrtt_pkg::SLOT_RUNNING;
               current = idx;
               moved = 1'b1;
            end
            k = SLOTS + 1;
         end
      end
      return moved;
   endfunction

   function void note_request(rrtt_pkg::action_type act, logic [3:0] tgt);
      rrtt_pkg::result_type word;
      bit                   found;
      word = '0;
      word.status = rrtt_pkg::STAT_OK;
      word.previous_id = current[rrtt_pkg::ID_OUT_W-1:0];
      found = 1'b0;
      case (act)
         rrtt_pkg::ACT_CREATE: begin
            word.status = rrtt_pkg::STAT_FULL;
            for (int k = 0; k < SLOTS; k++) begin
               if (!found && slot_state[k] == rrtt_pkg::SLOT_UNUSED) begin
                  slot_state[k] = rrtt_pkg::SLOT_RUNNABLE;
                  word.created_id = k[rrtt_pkg::ID_OUT_W-1:0];
                  word.status = rrtt_pkg::STAT_OK;
                  found = 1'b1;
               end
            end
         end
         rrtt_pkg::ACT_YIELD: word.switched = rotate_to_next();
         rrtt_pkg::ACT_EXIT: begin
            slot_state[current] = rrtt_pkg::SLOT_FINISHED;
            word.switched = rotate_to_next();
         end
         default: begin
            if (tgt >= SLOTS) begin
               word.status = rrtt_pkg::STAT_BAD_ID;
            end else if (slot_state[tgt] == rrtt_pkg::SLOT_FINISHED) begin
               slot_state[tgt] = rrtt_pkg::SLOT_UNUSED;
            end else if (slot_state[tgt] != rrtt_pkg::SLOT_UNUSED) begin
               word.switched = rotate_to_next();
               word.status = rrtt_pkg::STAT_WAITING;
            end
         end
      endcase
      word.running_id = current[rrtt_pkg::ID_OUT_W-1:0];
      pending_responses.push_back(word);
      words_in++;
      status_tally[word.status]++;
      if (word.switched) switch_tally++;
   endfunction

   function void check_response(rrtt_pkg::result_type got);
      rrtt_pkg::result_type want;
      words_out++;
      if (pending_responses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: response word %0d with nothing outstanding: st=%0d cr=%0d sw=%0d pv=%0d rn=%0d",
                     words_out, got.status, got.created_id, got.switched,
                     got.previous_id, got.running_id);
         return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status || got.created_id !== want.created_id ||
          got.switched !== want.switched || got.previous_id !== want.previous_id ||
          got.running_id !== want.running_id) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: response word %0d mismatch", words_out);
            $display("   expected st=%0d cr=%0d sw=%0d pv=%0d rn=%0d", want.status,
                     want.created_id, want.switched, want.previous_id, want.running_id);
            $display("   actual   st=%0d cr=%0d sw=%0d pv=%0d rn=%0d", got.status,
                     got.created_id, got.switched, got.previous_id, got.running_id);
         end
      end
   endfunction

   function int unsigned pending();
      return pending_responses.size();
   endfunction
endclass

module round_robin_thread_table_test;

   localparam int RANDOM_WORDS    = 480;
   localparam int QUIET_TAIL      = 100;  // last random words run with no idling
   localparam int STRETCH         = 40;   // idling is re-chosen every stretch
   localparam int HOLD_OFF_AT     = 240;  // random word that triggers the long stall
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;   // beyond the worst scan latency

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [3:0] req_target_id;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic [2:0] rsp_created_id;
   logic       rsp_switched;
   logic [2:0] rsp_previous_id;
   logic [2:0] rsp_running_id;

   // Idling controls, set by the request side and read by both sides.
   bit sender_idle;
   bit receiver_idle;
   bit hold_off_request;

   thread_table_scoreboard tracker;

   round_robin_thread_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_target_id   (req_target_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_created_id  (rsp_created_id),
      .rsp_switched    (rsp_switched),
      .rsp_previous_id (rsp_previous_id),
      .rsp_running_id  (rsp_running_id)
   );

   always #5 clock = ~clock;

   // Safety net: far beyond the slowest legal run (clear pass, long stall,
   // worst gaps and scans on every word).
   initial begin
      #5_000_000;
      $display("round_robin_thread_table verification failed");
      $finish;
   end

   // Offer one request word, with an optional idle burst first, and hold it
   // until the handshake. Called at a rising edge; returns at the accepting edge,
   // so valid need not drop between one word and the next.
   task automatic send_word(input rrtt_pkg::action_type act, input logic [3:0] tgt);
      int unsigned gap;
      gap = 0;
      if (sender_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_target_id <= tgt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(act, tgt);
   endtask

   // Random word: creates, yields and exits in a mix that keeps the table
   // cycling through full, finished and empty; joins mostly in range.
   task automatic send_random_word();
      rrtt_pkg::action_type act;
      logic [3:0]           tgt;
      int unsigned          pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      act = rrtt_pkg::ACT_CREATE;
      else if (pick < 55) act = rrtt_pkg::ACT_YIELD;
      else if (pick < 72) act = rrtt_pkg::ACT_EXIT;
      else                act = rrtt_pkg::ACT_JOIN;
      if (act == rrtt_pkg::ACT_JOIN && $urandom_range(0, 9) != 0)
         tgt = 4'($urandom_range(0, 7));
      else
         tgt = 4'($urandom_range(0, 15));
      send_word(act, tgt);
   endtask

   // Request side: reset, directed words, random words, drain, verdict.
   initial begin
      tracker = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= rrtt_pkg::ACT_CREATE;
      req_target_id    <= 4'd0;
      sender_idle      = 1'b1;
      receiver_idle    = 1'b1;
      hold_off_request = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table cases first, then fill, overflow and joins.
      send_word(rrtt_pkg::ACT_YIELD, 4'd0);    // only the running slot exists: no switch
      send_word(rrtt_pkg::ACT_EXIT, 4'hF);     // exit with nothing to run: stays current
      send_word(rrtt_pkg::ACT_JOIN, 4'd0);     // frees the finished current slot
      send_word(rrtt_pkg::ACT_CREATE, 4'hA);   // reuses slot 0
      send_word(rrtt_pkg::ACT_YIELD, 4'd5);    // only the current slot runnable: no switch
      repeat (7) send_word(rrtt_pkg::ACT_CREATE, 4'd0);
      send_word(rrtt_pkg::ACT_CREATE, 4'h5);   // table full
      send_word(rrtt_pkg::ACT_JOIN, 4'd15);    // out-of-range ids
      send_word(rrtt_pkg::ACT_JOIN, 4'd8);
      send_word(rrtt_pkg::ACT_YIELD, 4'd0);
      send_word(rrtt_pkg::ACT_JOIN, 4'd1);     // join of the running slot: waits
      send_word(rrtt_pkg::ACT_JOIN, 4'd3);     // join of a runnable slot: waits
      send_word(rrtt_pkg::ACT_EXIT, 4'd0);
      send_word(rrtt_pkg::ACT_JOIN, 4'd3);     // join of a finished slot: freed
      send_word(rrtt_pkg::ACT_JOIN, 4'd3);     // join of an unused slot: ok
      send_word(rrtt_pkg::ACT_JOIN, 4'd7);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n >= RANDOM_WORDS - QUIET_TAIL) begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
         end else if (n % STRETCH == 0) begin
            sender_idle   = ($urandom_range(0, 2) != 0);
            receiver_idle = ($urandom_range(0, 2) != 0);
         end
         if (n == HOLD_OFF_AT) hold_off_request = 1'b1;
         send_random_word();
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request words, %0d responses, %0d switches, one long output stall.",
               tracker.words_in, tracker.words_out, tracker.switch_tally);
      $display("Status mix: ok %0d, full %0d, bad id %0d, waiting %0d; %0d mismatches.",
               tracker.status_tally[rrtt_pkg::STAT_OK],
               tracker.status_tally[rrtt_pkg::STAT_FULL],
               tracker.status_tally[rrtt_pkg::STAT_BAD_ID],
               tracker.status_tally[rrtt_pkg::STAT_WAITING],
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("round_robin_thread_table verification clean");
      end else begin
         $display("round_robin_thread_table verification failed");
      end
      $finish;
   end

   // Response side: check every accepted word, then pick next cycle's ready.
   // Random stall bursts, plus one long hold-off so the block backs up
   // and drops req_ready while words keep being offered.
   initial begin
      int unsigned          stall_left;
      rrtt_pkg::result_type got;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.status      = rrtt_pkg::status_type'(rsp_status);
            got.created_id  = rsp_created_id;
            got.switched    = rsp_switched;
            got.previous_id = rsp_previous_id;
            got.running_id  = rsp_running_id;
            tracker.check_response(got);
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule

// File: sim.f
+incdir+design
design/rrtt_pkg.sv
design/rrtt_engine.sv
design/round_robin_thread_table.sv
design/rrtt_checker.sv
dv/round_robin_thread_table_test.sv
